// ----- src/dns_answer_address_extractor_macros.svh -----
// Assertion macros for the DNS answer address extractor.
`ifndef DNS_ANSWER_ADDRESS_EXTRACTOR_MACROS_SVH
`define DNS_ANSWER_ADDRESS_EXTRACTOR_MACROS_SVH

`ifndef SYNTH
`define DNSAE_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dnsae assertion failed");
`define DNSAE_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("dnsae assertion failed");
`else
`define DNSAE_ASSERT(name, clk, rst_n, prop)
`define DNSAE_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// ----- src/dnsae_pkg.sv -----
package dnsae_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_RCODE   = 3'd1,
    ST_NO_ADDR = 3'd2,
    ST_LABEL   = 3'd3,
    ST_TRUNC   = 3'd4
  } status_e;

  // One entry per input byte that yields results: an address, an end status, or both.
  typedef struct packed {
    logic        has_addr;
    logic        has_end;
    logic [31:0] addr;
    logic [31:0] ttl;
    logic [15:0] rec_addr;
    logic [15:0] rec_end;
    status_e     status;
  } evt_t;

endpackage

// ----- src/dnsae_front.sv -----
module dnsae_front #(
  parameter int unsigned MAX_PACKET_BYTES = 512
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  output logic              evt_valid_o,
  output dnsae_pkg::evt_t   evt_o
);
  import dnsae_pkg::*;

  localparam int unsigned PosW = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [7:0]  PtrMask  = 8'hC0;
  localparam logic [7:0]  MaxLabel = 8'd63;
  localparam logic [15:0] TypeA    = 16'h0001;
  localparam logic [15:0] AddrLen  = 16'd4;
  localparam logic [15:0] FixedLen = 16'd10;
  localparam logic [15:0] QTail    = 16'd6;
  localparam int unsigned FlRcode = 0;
  localparam int unsigned FlAddr  = 1;
  localparam int unsigned FlLabel = 2;
  localparam int unsigned FlTrunc = 3;

  typedef enum logic [8:0] {
    PH_HEADER   = 9'b000000001,
    PH_QUESTION = 9'b000000010,
    PH_NAME     = 9'b000000100,
    PH_LABEL    = 9'b000001000,
    PH_POINTER  = 9'b000010000,
    PH_FIXED    = 9'b000100000,
    PH_SKIP     = 9'b001000000,
    PH_ADDR     = 9'b010000000,
    PH_DONE     = 9'b100000000
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [15:0]      skip_q, skip_d;
  logic [15:0]      ans_q, ans_d;
  logic [15:0]      rec_q, rec_d;
  logic [3:0]       flags_q, flags_d;
  logic [7:0]       qlen_q, qlen_d;
  logic [15:0]      rtype_q, rtype_d;
  logic [31:0]      shift_q, shift_d;
  logic [31:0]      ttl_q, ttl_d;

  logic [15:0] skip_m1, ans_m1, rdlen;
  logic [31:0] shift_in;

  assign skip_m1  = skip_q - 16'd1;
  assign ans_m1   = ans_q - 16'd1;
  assign shift_in = {shift_q[23:0], data_byte_i};
  assign rdlen    = shift_in[15:0];

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    skip_d  = skip_q;
    ans_d   = ans_q;
    rec_d   = rec_q;
    flags_d = flags_q;
    qlen_d  = qlen_q;
    rtype_d = rtype_q;
    shift_d = shift_q;
    ttl_d   = ttl_q;
    evt_o   = '0;
    evt_o.status = ST_OK;

    if (cfg_we_i) begin
      qlen_d = cfg_wdata_i;
    end

    if (accept_i) begin
      if (pos_q >= PosW'(MAX_PACKET_BYTES)) begin
        flags_d[FlTrunc] = 1'b1;
      end else begin
        pos_d = pos_q + PosW'(1);
        case (phase_q)
          PH_HEADER: begin
            if (pos_q == PosW'(3) && data_byte_i[3:0] != 4'd0) begin
              flags_d[FlRcode] = 1'b1;
            end
            if (pos_q == PosW'(6)) begin
              ans_d = {data_byte_i, 8'd0};
            end
            if (pos_q == PosW'(7)) begin
              ans_d = {ans_q[15:8], data_byte_i};
            end
            if (pos_q == PosW'(11)) begin
              if (flags_q[FlRcode]) begin
                phase_d = PH_DONE;
              end else begin
                skip_d  = {8'd0, qlen_q} + QTail;
                phase_d = PH_QUESTION;
              end
            end
          end
          PH_QUESTION: begin
            skip_d = skip_m1;
            if (skip_m1 == 16'd0) begin
              phase_d = (ans_q != 16'd0) ? PH_NAME : PH_DONE;
            end
          end
          PH_NAME: begin
            if (data_byte_i == 8'd0) begin
              phase_d = PH_FIXED;
              skip_d  = FixedLen;
              shift_d = '0;
            end else if ((data_byte_i & PtrMask) == PtrMask) begin
              phase_d = PH_POINTER;
            end else begin
              if (data_byte_i > MaxLabel) begin
                flags_d[FlLabel] = 1'b1;
              end
              skip_d  = {8'd0, data_byte_i};
              phase_d = PH_LABEL;
            end
          end
          PH_LABEL: begin
            skip_d = skip_m1;
            if (skip_m1 == 16'd0) begin
              phase_d = PH_NAME;
            end
          end
          PH_POINTER: begin
            phase_d = PH_FIXED;
            skip_d  = FixedLen;
            shift_d = '0;
          end
          PH_FIXED: begin
            // skip counts down 10..1 across type, class, ttl, rdlength
            skip_d  = skip_m1;
            shift_d = shift_in;
            if (skip_q == 16'd9) begin
              rtype_d = shift_in[15:0];
              shift_d = '0;
            end else if (skip_q == 16'd7) begin
              shift_d = '0;
            end else if (skip_q == 16'd3) begin
              ttl_d   = shift_in;
              shift_d = '0;
            end else if (skip_q <= 16'd1) begin
              shift_d = '0;
              skip_d  = rdlen;
              if (rtype_q == TypeA && rdlen == AddrLen) begin
                phase_d = PH_ADDR;
              end else if (rdlen == 16'd0) begin
                rec_d   = rec_q + 16'd1;
                ans_d   = ans_m1;
                phase_d = (ans_m1 != 16'd0) ? PH_NAME : PH_DONE;
              end else begin
                phase_d = PH_SKIP;
              end
            end
          end
          PH_SKIP: begin
            skip_d = skip_m1;
            if (skip_m1 == 16'd0) begin
              rec_d   = rec_q + 16'd1;
              ans_d   = ans_m1;
              phase_d = (ans_m1 != 16'd0) ? PH_NAME : PH_DONE;
            end
          end
          PH_ADDR: begin
            shift_d = shift_in;
            skip_d  = skip_m1;
            if (skip_m1 == 16'd0) begin
              evt_o.has_addr  = 1'b1;
              evt_o.addr      = shift_in;
              evt_o.ttl       = ttl_q;
              evt_o.rec_addr  = rec_q;
              flags_d[FlAddr] = 1'b1;
              shift_d         = '0;
              rec_d           = rec_q + 16'd1;
              ans_d           = ans_m1;
              phase_d         = (ans_m1 != 16'd0) ? PH_NAME : PH_DONE;
            end
          end
          PH_DONE: begin
          end
          default: begin
          end
        endcase
      end

      if (last_byte_i) begin
        evt_o.has_end = 1'b1;
        evt_o.rec_end = rec_d;
        if (flags_d[FlRcode]) begin
          evt_o.status = ST_RCODE;
        end else if (flags_d[FlLabel]) begin
          evt_o.status = ST_LABEL;
        end else if (flags_d[FlTrunc] || phase_d != PH_DONE) begin
          evt_o.status = ST_TRUNC;
        end else if (!flags_d[FlAddr]) begin
          evt_o.status = ST_NO_ADDR;
        end else begin
          evt_o.status = ST_OK;
        end
        phase_d = PH_HEADER;
        pos_d   = '0;
        skip_d  = '0;
        ans_d   = '0;
        rec_d   = '0;
        flags_d = '0;
      end
    end
  end

  assign evt_valid_o = accept_i && (evt_o.has_addr || evt_o.has_end);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      pos_q   <= '0;
      skip_q  <= '0;
      ans_q   <= '0;
      rec_q   <= '0;
      flags_q <= '0;
      qlen_q  <= 8'd1;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      skip_q  <= skip_d;
      ans_q   <= ans_d;
      rec_q   <= rec_d;
      flags_q <= flags_d;
      qlen_q  <= qlen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rtype_q <= rtype_d;
    shift_q <= shift_d;
    ttl_q   <= ttl_d;
  end

endmodule

// ----- src/dnsae_fifo.sv -----
`include "dns_answer_address_extractor_macros.svh"

module dnsae_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  dnsae_pkg::evt_t wdata_i,
  input  logic            pop_i,
  output dnsae_pkg::evt_t rdata_o,
  output logic            full_o,
  output logic            empty_o
);
  import dnsae_pkg::*;

  evt_t              mem_q [QDepth];
  logic [QPtrW-1:0]  wr_q, wr_d;
  logic [QPtrW-1:0]  rd_q, rd_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = wr_q + QPtrW'(1);
    end
    if (pop_i) begin
      rd_d = rd_q + QPtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  `DNSAE_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= QCntW'(QDepth))
  `DNSAE_ASSERT(a_no_pop_empty, clk_i, rst_ni, empty_o |-> !pop_i)
  `DNSAE_ASSERT(a_no_push_full, clk_i, rst_ni, full_o |-> !push_i)
  `DNSAE_ASSERT(a_ptr_gap, clk_i, rst_ni, (wr_q - rd_q) == cnt_q[QPtrW-1:0])

endmodule

// ----- src/dnsae_back.sv -----
`include "dns_answer_address_extractor_macros.svh"

module dnsae_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  dnsae_pkg::evt_t q_rdata_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            out_kind_o,
  output logic [31:0]     out_addr_o,
  output logic [31:0]     out_ttl_o,
  output logic [15:0]     out_rec_o,
  output logic [2:0]      out_status_o,
  output logic            out_last_o
);
  import dnsae_pkg::*;

  evt_t ent_q;
  logic ent_vld_q;
  logic addr_pend_q;
  logic take, done, load;

  assign take    = ent_vld_q && out_ready_i;
  assign done    = take && !(addr_pend_q && ent_q.has_end);
  assign load    = !ent_vld_q || done;
  assign q_pop_o = load && !q_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q   <= 1'b0;
      addr_pend_q <= 1'b0;
    end else if (q_pop_o) begin
      ent_vld_q   <= 1'b1;
      addr_pend_q <= q_rdata_i.has_addr;
    end else if (done) begin
      ent_vld_q   <= 1'b0;
      addr_pend_q <= 1'b0;
    end else if (take) begin
      addr_pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      ent_q <= q_rdata_i;
    end
  end

  // address beat goes out first when a byte yields both
  assign out_valid_o  = ent_vld_q;
  assign out_kind_o   = !addr_pend_q;
  assign out_addr_o   = addr_pend_q ? ent_q.addr : 32'd0;
  assign out_ttl_o    = addr_pend_q ? ent_q.ttl : 32'd0;
  assign out_rec_o    = addr_pend_q ? ent_q.rec_addr : ent_q.rec_end;
  assign out_status_o = addr_pend_q ? ST_OK : ent_q.status;
  assign out_last_o   = addr_pend_q ? !ent_q.has_end : 1'b1;

  `DNSAE_ASSERT(a_pend_needs_vld, clk_i, rst_ni, addr_pend_q |-> ent_vld_q)
  `DNSAE_ASSERT(a_split_keeps, clk_i, rst_ni,
                (take && addr_pend_q && ent_q.has_end) |=> (ent_vld_q && !addr_pend_q))

endmodule

// ----- src/dns_answer_address_extractor.sv -----
// DNS response parser: takes one message byte per clock on the slave stream
// (tlast on the final byte) and returns a result beat for each type A answer
// with a 4-byte address, then an end-status beat on the final byte. Input
// ready depends only on the 4-entry result queue, so bytes are accepted every
// clock unless the queue is full; the output side delivers one result per
// clock while the receiver is ready, so a byte that closes both an A record
// and the message takes two output beats. Bytes beyond MAX_PACKET_BYTES are
// not parsed and flag the message as truncated. query_name_length must only
// be written between messages.
module dns_answer_address_extractor #(
  parameter int unsigned MAX_PACKET_BYTES = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // [31:0] host_address, [63:32] time_to_live,
                                      // [79:64] record_number, [82:80] status
  output logic        m_axis_tuser,   // result_kind
  output logic        m_axis_tlast    // last
);
  import dnsae_pkg::*;

  logic        accept;
  logic        evt_valid;
  evt_t        evt;
  evt_t        q_rdata;
  logic        q_full, q_empty, q_pop;
  logic [31:0] out_addr, out_ttl;
  logic [15:0] out_rec;
  logic [2:0]  out_status;

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  dnsae_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (s_axis_tdata),
    .last_byte_i (s_axis_tlast),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .evt_valid_o (evt_valid),
    .evt_o       (evt)
  );

  dnsae_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (evt_valid),
    .wdata_i (evt),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  dnsae_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_rdata_i    (q_rdata),
    .q_pop_o      (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_kind_o   (m_axis_tuser),
    .out_addr_o   (out_addr),
    .out_ttl_o    (out_ttl),
    .out_rec_o    (out_rec),
    .out_status_o (out_status),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, out_status, out_rec, out_ttl, out_addr};

endmodule

// ----- bench/dns_answer_address_extractor_tb.sv -----
`timescale 1ns / 100ps

module dns_answer_address_extractor_tb;
  import dnsae_pkg::*;

  localparam int MAX_MSG_BYTES = 512;
  localparam int TOTAL_BYTES = 1250;
  localparam int SQUEEZE_CYCLES = 400;
  localparam int SETTLE_CYCLES = 6;
  localparam int IDLE_LIMIT = 3000;
  localparam bit [15:0] TYPE_A = 16'h0001;
  localparam bit [15:0] TYPE_CNAME = 16'h0005;
  localparam logic KIND_ADDR = 1'b0;
  localparam logic KIND_END = 1'b1;

  typedef enum logic [3:0] {
    AT_HEADER, AT_QUESTION, AT_NAME, AT_LABEL, AT_POINTER,
    AT_FIXED, AT_SKIP, AT_ADDR, AT_DONE
  } parse_step_e;

  typedef enum logic [1:0] {NAME_PTR, NAME_LABELS, NAME_LABELS_PTR, NAME_ROOT} name_form_e;

  typedef struct packed {
    logic        kind;
    logic [31:0] host;
    logic [31:0] ttl;
    logic [15:0] rec;
    status_e     status;
    logic        last;
  } dns_result_t;

  class dns_answer_predictor;
    dns_result_t pending_results[$];
    dns_result_t fresh[$];
    int mismatches;
    int addr_expected;
    int end_expected;
    bit [7:0] name_len;
    parse_step_e phase;
    int byte_pos;
    bit [15:0] to_skip;
    bit [15:0] answers_left;
    bit [15:0] rtype;
    bit [15:0] record_index;
    bit [31:0] shift;
    bit [31:0] ttl_hold;
    bit rcode_seen, addr_seen, label_seen, trunc_seen;

    function new();
      name_len = 8'd1;
      clear_parse();
    endfunction

    function void clear_parse();
      phase = AT_HEADER;
      byte_pos = 0;
      to_skip = '0;
      answers_left = '0;
      rtype = '0;
      shift = '0;
      ttl_hold = '0;
      record_index = '0;
      rcode_seen = 0;
      addr_seen = 0;
      label_seen = 0;
      trunc_seen = 0;
    endfunction

    function void set_name_len(bit [7:0] v);
      name_len = v;
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    function void add_fresh(logic kind, logic [31:0] host, logic [31:0] ttl,
                            logic [15:0] rec, status_e st);
      dns_result_t r;
      r.kind = kind;
      r.host = host;
      r.ttl = ttl;
      r.rec = rec;
      r.status = st;
      r.last = 1'b0;
      fresh.push_back(r);
    endfunction

    function void finish_record();
      record_index++;
      answers_left--;
      phase = (answers_left != 0) ? AT_NAME : AT_DONE;
    endfunction

    function void parse(bit [7:0] b, int pos);
      int idx;
      bit [15:0] rdlen;
      case (phase)
        AT_HEADER: begin
          if (pos == 3 && b[3:0] != 4'h0) rcode_seen = 1;
          if (pos == 6) answers_left = {b, 8'h00};
          if (pos == 7) answers_left = answers_left | {8'h00, b};
          if (pos == 11) begin
            if (rcode_seen) begin
              phase = AT_DONE;
            end else begin
              to_skip = {8'h00, name_len} + 16'd6;
              phase = AT_QUESTION;
            end
          end
        end
        AT_QUESTION: begin
          to_skip--;
          if (to_skip == 0) phase = (answers_left != 0) ? AT_NAME : AT_DONE;
        end
        AT_NAME: begin
          if (b == 8'h00) begin
            phase = AT_FIXED;
            to_skip = 16'd10;
            shift = '0;
          end else if (b[7:6] == 2'b11) begin
            phase = AT_POINTER;
          end else begin
            if (b > 8'd63) label_seen = 1;
            to_skip = {8'h00, b};
            phase = AT_LABEL;
          end
        end
        AT_LABEL: begin
          to_skip--;
          if (to_skip == 0) phase = AT_NAME;
        end
        AT_POINTER: begin
          phase = AT_FIXED;
          to_skip = 16'd10;
          shift = '0;
        end
        AT_FIXED: begin
          idx = 10 - int'(to_skip);
          to_skip--;
          shift = {shift[23:0], b};
          if (idx == 1) begin
            rtype = shift[15:0];
            shift = '0;
          end else if (idx == 3) begin
            shift = '0;
          end else if (idx == 7) begin
            ttl_hold = shift;
            shift = '0;
          end else if (idx >= 9) begin
            rdlen = shift[15:0];
            shift = '0;
            to_skip = rdlen;
            if (rtype == TYPE_A && rdlen == 16'd4) phase = AT_ADDR;
            else if (rdlen == 0) finish_record();
            else phase = AT_SKIP;
          end
        end
        AT_SKIP: begin
          to_skip--;
          if (to_skip == 0) finish_record();
        end
        AT_ADDR: begin
          shift = {shift[23:0], b};
          to_skip--;
          if (to_skip == 0) begin
            add_fresh(KIND_ADDR, shift, ttl_hold, record_index, ST_OK);
            addr_expected++;
            addr_seen = 1;
            shift = '0;
            finish_record();
          end
        end
        default: ;
      endcase
    endfunction

    function void take_byte(bit [7:0] b, bit fin);
      status_e st;
      dns_result_t r;
      if (byte_pos >= MAX_MSG_BYTES) begin
        trunc_seen = 1;
      end else begin
        byte_pos++;
        parse(b, byte_pos - 1);
      end
      if (fin) begin
        if (rcode_seen) st = ST_RCODE;
        else if (label_seen) st = ST_LABEL;
        else if (trunc_seen || phase != AT_DONE) st = ST_TRUNC;
        else if (!addr_seen) st = ST_NO_ADDR;
        else st = ST_OK;
        add_fresh(KIND_END, '0, '0, record_index, st);
        end_expected++;
        clear_parse();
      end
      while (fresh.size() != 0) begin
        r = fresh.pop_front();
        r.last = (fresh.size() == 0);
        pending_results.push_back(r);
      end
    endfunction

    function void compare_field(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        mismatches++;
      end
    endfunction

    function void match_result(logic kind, logic [31:0] host, logic [31:0] ttl,
                               logic [15:0] rec, logic [2:0] st, logic last,
                               logic [4:0] pad);
      dns_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got kind %0d rec %0d st %0d",
                 $time, kind, rec, st);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("result_kind", want.kind, kind);
      compare_field("host_address", want.host, host);
      compare_field("time_to_live", want.ttl, ttl);
      compare_field("record_number", want.rec, rec);
      compare_field("status", want.status, st);
      compare_field("last", want.last, last);
      compare_field("tdata padding", '0, pad);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  dns_answer_address_extractor dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  dns_answer_predictor sb;
  bit [7:0] msg[$];
  bit [7:0] name_len_now = 8'd1;
  bit squeeze_req = 0;
  int bytes_sent = 0;
  int messages_sent = 0;
  int settings_used = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(8, 30);
  endfunction

  function automatic int pick_label_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 90) return $urandom_range(1, 12);
    else if (r < 95) return 63;
    else return $urandom_range(13, 62);
  endfunction

  function automatic bit [7:0] pick_name_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'($urandom_range(1, 16));
    else if (r < 95) return 8'($urandom_range(17, 120));
    else return 8'($urandom_range(200, 253));
  endfunction

  function automatic void push_rand(int n);
    bit [7:0] v;
    for (int i = 0; i < n; i++) begin
      v = 8'($urandom);
      msg.push_back(v);
    end
  endfunction

  function automatic void push_be(bit [31:0] v, int n_bytes);
    for (int i = n_bytes - 1; i >= 0; i--) msg.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_header(bit [3:0] rcode, bit [15:0] ancount);
    bit [7:0] hi;
    hi = 8'($urandom);
    push_rand(3);
    msg.push_back({hi[7:4], rcode});
    push_rand(2);
    push_be(ancount, 2);
    push_rand(4);
  endfunction

  function automatic void put_question();
    push_rand(name_len_now + 6);
  endfunction

  function automatic void push_pointer();
    bit [7:0] v;
    v = 8'($urandom);
    msg.push_back(v | 8'hc0);
    push_rand(1);
  endfunction

  // first_len > 0 fixes the length of the first label
  function automatic void add_answer(name_form_e form, bit [15:0] rtype, bit [15:0] rdlen,
                                     bit [31:0] ttl, bit [31:0] host, int first_len);
    int n_labels;
    int len;
    if (form == NAME_PTR) begin
      push_pointer();
    end else if (form == NAME_ROOT) begin
      msg.push_back(8'h00);
    end else begin
      n_labels = $urandom_range(1, 3);
      for (int i = 0; i < n_labels; i++) begin
        len = (i == 0 && first_len > 0) ? first_len : pick_label_len();
        msg.push_back(8'(len));
        push_rand(len);
      end
      if (form == NAME_LABELS_PTR) push_pointer();
      else msg.push_back(8'h00);
    end
    push_be(rtype, 2);
    push_rand(2);
    push_be(ttl, 4);
    push_be(rdlen, 2);
    if (rtype == TYPE_A && rdlen == 16'd4) push_be(host, 4);
    else push_rand((rdlen > 24) ? 24 : rdlen);
  endfunction

  function automatic void add_random_answer();
    name_form_e form;
    bit [15:0] rtype;
    bit [15:0] rdlen;
    int r;
    int long_len;
    form = name_form_e'($urandom_range(0, 3));
    r = $urandom_range(0, 99);
    rtype = (r < 65) ? TYPE_A : (r < 80) ? TYPE_CNAME : 16'($urandom);
    if (rtype == TYPE_A) rdlen = ($urandom_range(0, 9) != 0) ? 16'd4 : 16'($urandom_range(0, 8));
    else rdlen = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
    long_len = ($urandom_range(0, 39) == 0) ? $urandom_range(64, 191) : 0;
    if (long_len > 0 && (form == NAME_PTR || form == NAME_ROOT)) form = NAME_LABELS;
    add_answer(form, rtype, rdlen, $urandom, $urandom, long_len);
  endfunction

  // answers keep coming until the message runs past the size limit
  function automatic void build_oversized_message();
    msg.delete();
    put_header(4'h0, 16'd40);
    put_question();
    while (msg.size() < MAX_MSG_BYTES) add_random_answer();
    push_rand($urandom_range(1, 16));
  endfunction

  function automatic void build_random_message();
    int r;
    int n_ans;
    int cut;
    bit [15:0] ancount;
    msg.delete();
    r = $urandom_range(0, 99);
    if (r < 6) begin
      push_rand($urandom_range(1, 40));
      return;
    end
    n_ans = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
    ancount = 16'(n_ans);
    if (r < 9) ancount = 16'($urandom);
    put_header((r >= 9 && r < 15) ? 4'($urandom_range(1, 15)) : 4'h0, ancount);
    put_question();
    for (int i = 0; i < n_ans; i++) add_random_answer();
    if (r >= 15 && r < 25) begin
      cut = $urandom_range(1, msg.size() - 1);
      while (msg.size() > cut) void'(msg.pop_back());
    end else if (r >= 25 && r < 35) begin
      push_rand($urandom_range(1, 8));
    end
  endfunction

  task automatic send_byte(bit [7:0] d, bit fin, int gap);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    s_axis_tlast <= fin;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.take_byte(d, fin);
    bytes_sent++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_message(bit calm);
    for (int i = 0; i < msg.size(); i++)
      send_byte(msg[i], i == msg.size() - 1, calm ? 0 : pick_gap());
    messages_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_name_len(bit [7:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_name_len(v);
    name_len_now = v;
    settings_used++;
  endtask

  task automatic run_directed();
    // lone byte, message ends inside the header
    msg.delete();
    msg.push_back(8'h5a);
    send_message(0);
    // server error, message stops after the header
    msg.delete();
    put_header(4'h3, 16'd1);
    send_message(1);
    // no answers at all
    msg.delete();
    put_header(4'h0, 16'd0);
    put_question();
    send_message(0);
    // every name form, CNAME, A with 6-byte rdlength, unknown type with empty rdata
    msg.delete();
    put_header(4'h0, 16'd5);
    put_question();
    add_answer(NAME_PTR, TYPE_A, 16'd4, 32'hffff_ffff, 32'hffff_ffff, 0);
    add_answer(NAME_LABELS, TYPE_CNAME, 16'd3, '0, '0, 0);
    add_answer(NAME_LABELS_PTR, TYPE_A, 16'd4, '0, '0, 0);
    add_answer(NAME_ROOT, TYPE_A, 16'd6, $urandom, $urandom, 0);
    add_answer(NAME_ROOT, 16'hffff, 16'd0, $urandom, $urandom, 0);
    send_message(0);
    // over-long label; address and end status both on the final byte
    msg.delete();
    put_header(4'h0, 16'd1);
    put_question();
    add_answer(NAME_LABELS, TYPE_A, 16'd4, $urandom, $urandom, 64);
    send_message(1);
    // 63-byte label is legal; second record cut short
    msg.delete();
    put_header(4'h0, 16'd2);
    put_question();
    add_answer(NAME_LABELS, TYPE_A, 16'd4, $urandom, $urandom, 63);
    add_answer(NAME_PTR, TYPE_A, 16'd4, $urandom, $urandom, 0);
    repeat (6) void'(msg.pop_back());
    send_message(0);
  endtask

  initial begin : receiver
    int stall_left;
    bit calm;
    stall_left = 0;
    calm = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready)
        sb.match_result(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32],
                        m_axis_tdata[79:64], m_axis_tdata[82:80], m_axis_tlast,
                        m_axis_tdata[87:83]);
      if ($urandom_range(0, 149) == 0) calm = !calm;
      if (squeeze_req) begin
        squeeze_req = 0;
        stall_left = SQUEEZE_CYCLES;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm) stall_left = pick_gap();
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    @(posedge rst_ni);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle = 0;
      else idle++;
    end
    $display("%0t: no beat on either side for %0d cycles", $time, IDLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    drain_results();

    // receiver holds off while short messages pile up behind it
    squeeze_req = 1;
    repeat (8) begin
      msg.delete();
      push_rand($urandom_range(1, 12));
      send_message(1);
    end
    drain_results();

    // longest question, then a message that runs past the size limit
    write_name_len(8'd253);
    build_oversized_message();
    send_message(0);
    drain_results();

    while (bytes_sent < TOTAL_BYTES) begin
      write_name_len(pick_name_len());
      repeat ($urandom_range(3, 8)) begin
        if (bytes_sent < TOTAL_BYTES) begin
          build_random_message();
          send_message($urandom_range(0, 3) == 0);
        end
      end
      drain_results();
    end

    $display("Sent %0d messages (%0d bytes) over %0d name length settings;",
             messages_sent, bytes_sent, settings_used);
    $display("checked %0d address beats and %0d end-status beats.",
             sb.addr_expected, sb.end_expected);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
